// File: rtl/fwqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwqr_pkg: shared types for the wait queue with removal
// Operation codes, status codes, cell commands, controller states and the chain summary.
// ----------------------------------------------------------------------------
package fwqr_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int ID_WIDTH_DEFAULT = 8;

   // Request operation codes
   typedef enum logic [1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_DEQUEUE = 2'd1,
      KIND_DEQ_ALL = 2'd2,
      KIND_REMOVE  = 2'd3
   } kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_SHIFT,
      CMD_MATCH,
      CMD_SHIFT_SEEN
   } cell_cmd_type;

   // Controller states
   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Chain summary seen by the controller
   typedef struct packed {
      logic head_valid;
      logic next_valid;
      logic full;
      logic found;
   } chain_status_type;

endpackage

// File: rtl/fwqr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwqr_req_if: request channel
// Valid/ready channel carrying one queue operation.
// ----------------------------------------------------------------------------
interface fwqr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] task_id;

   modport source (output valid, output kind, output task_id, input ready);
   modport sink   (input valid, input kind, input task_id, output ready);
endinterface

// File: rtl/fwqr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwqr_rsp_if: result channel
// Valid/ready channel carrying one result of a queue operation.
// ----------------------------------------------------------------------------
interface fwqr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_task;
   logic [1:0] status;
   logic       last;
   logic       now_empty;

   modport source (output valid, output out_task, output status, output last,
                   output now_empty, input ready);
   modport sink   (input valid, input out_task, input status, input last,
                   input now_empty, output ready);
endinterface

// File: rtl/fwqr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwqr_cell: one queue slot
// Holds one identifier and its valid bit, loads, shifts toward the head and
// takes part in the first-match search for removal.
// ----------------------------------------------------------------------------
module fwqr_cell
   import fwqr_pkg::*;
#(
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_cmd_type        cmd,
   input  logic [ID_WIDTH-1:0] in_id,
   input  logic [ID_WIDTH-1:0] nbr_slot,
   input  logic                nbr_valid,
   input  logic                prev_valid,
   input  logic                seen_in,
   output logic [ID_WIDTH-1:0] slot,
   output logic                valid,
   output logic                seen_out
);

   logic [ID_WIDTH-1:0] slot_ff, slot_in;
   logic                valid_ff, valid_in;
   logic                match_ff, match_in;

   // pass the first-match mark toward the tail
   assign seen_out = seen_in | match_ff;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      case (cmd)
         CMD_LOAD: begin
            if (!valid_ff && prev_valid) begin
               slot_in  = in_id;
               valid_in = 1'b1;
            end
         end
         CMD_SHIFT: begin
            slot_in  = nbr_slot;
            valid_in = nbr_valid;
         end
         CMD_MATCH: begin
            match_in = valid_ff && (slot_ff == in_id);
         end
         CMD_SHIFT_SEEN: begin
            if (seen_out) begin
               slot_in  = nbr_slot;
               valid_in = nbr_valid;
            end
         end
         default: begin
         end
      endcase
   end

   // hold occupancy under reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      slot_ff  <= slot_in;
      match_ff <= match_in;
   end

   assign slot  = slot_ff;
   assign valid = valid_ff;

endmodule

// File: rtl/fwqr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwqr_ctrl: queue sequencer
// Takes requests, drives the cell chain and fills the result register.
// ----------------------------------------------------------------------------
module fwqr_ctrl
   import fwqr_pkg::*;
#(
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   fwqr_req_if.sink            req,
   fwqr_rsp_if.source          rsp,
   input  chain_status_type    chain,
   input  logic [ID_WIDTH-1:0] head_slot,
   output cell_cmd_type        cmd,
   output logic [ID_WIDTH-1:0] cell_id
);

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          task_ff, task_in;
   status_type          status_ff, status_in;
   logic                last_ff, last_in;
   logic                empty_ff, empty_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign cell_id  = (state_ff == S_IDLE) ? ID_WIDTH'(req.task_id) : id_ff;

   // sequence one request: capture, then execute when the result slot frees
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      task_in      = task_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      cmd          = CMD_HOLD;
      req.ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               kind_in  = kind_type'(req.kind);
               id_in    = ID_WIDTH'(req.task_id);
               state_in = S_EXEC;
               if (kind_type'(req.kind) == KIND_REMOVE) begin
                  cmd = CMD_MATCH;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               task_in      = '0;
               last_in      = 1'b1;
               state_in     = S_IDLE;
               case (kind_ff)
                  KIND_ENQUEUE: begin
                     if (chain.full) begin
                        status_in = STATUS_FULL;
                        empty_in  = !chain.head_valid;
                     end else begin
                        cmd       = CMD_LOAD;
                        status_in = STATUS_OK;
                        empty_in  = 1'b0;
                     end
                  end
                  KIND_DEQUEUE: begin
                     if (!chain.head_valid) begin
                        status_in = STATUS_EMPTY;
                        empty_in  = 1'b1;
                     end else begin
                        cmd       = CMD_SHIFT;
                        task_in   = 8'(head_slot);
                        status_in = STATUS_OK;
                        empty_in  = !chain.next_valid;
                     end
                  end
                  KIND_DEQ_ALL: begin
                     empty_in = 1'b1;
                     if (!chain.head_valid) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cmd       = CMD_SHIFT;
                        task_in   = 8'(head_slot);
                        status_in = STATUS_OK;
                        last_in   = !chain.next_valid;
                        if (chain.next_valid) begin
                           state_in = S_EXEC;
                        end
                     end
                  end
                  KIND_REMOVE: begin
                     cmd = CMD_SHIFT_SEEN;
                     if (chain.found) begin
                        status_in = STATUS_OK;
                        empty_in  = !chain.next_valid;
                     end else begin
                        status_in = STATUS_NOT_FOUND;
                        empty_in  = !chain.head_valid;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // advance control state, hold payload
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      id_ff     <= id_in;
      task_ff   <= task_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_task  = task_ff;
   assign rsp.status    = status_ff;
   assign rsp.last      = last_ff;
   assign rsp.now_empty = empty_ff;

endmodule

// File: rtl/fifo_wait_queue_with_removal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_wait_queue_with_removal_unit: FIFO of task identifiers with removal
// A row of slot cells, oldest at the head, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries kind (enqueue, dequeue, dequeue all, remove) and task_id.
//   rsp carries out_task, status, last and now_empty; each request gives one
//   result, except dequeue-all on a non-empty queue, which gives one result
//   per entry, oldest first, with last set on the final one.
//   A request is taken in the idle state; in the execute state, once the
//   result register is free, it is executed and its result registered;
//   dequeue-all stays in the execute state for each further entry.
//   Removal compares all cells in the capture cycle and closes the gap in the
//   execute cycle; enqueue, dequeue and removal each move the chain once.
//   One request is in flight at a time; req.ready is high while idle.
//   When rsp stalls, execution waits until the result register frees; the
//   queue contents are held meanwhile.
//   Reset empties the queue at once; the slots need no clearing.
// ----------------------------------------------------------------------------
module fifo_wait_queue_with_removal_unit
   import fwqr_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fwqr_req_if.sink   req,
   fwqr_rsp_if.source rsp
);

   cell_cmd_type        cmd;
   logic [ID_WIDTH-1:0] cell_id;
   chain_status_type    chain;
   logic [ID_WIDTH-1:0] slot_pad  [DEPTH+1];
   logic [DEPTH:0]      valid_pad;
   logic [DEPTH:0]      seen_pad;
   logic                prev_valid [DEPTH];

   // pad the tail so the last cell shifts in an empty slot
   assign slot_pad[DEPTH]  = '0;
   assign valid_pad[DEPTH] = 1'b0;
   assign seen_pad[0]      = 1'b0;

   // build the cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_valid[i] = 1'b1;
      end else begin : g_body
         assign prev_valid[i] = valid_pad[i-1];
      end

      fwqr_cell #(
         .ID_WIDTH (ID_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .in_id      (cell_id),
         .nbr_slot   (slot_pad[i+1]),
         .nbr_valid  (valid_pad[i+1]),
         .prev_valid (prev_valid[i]),
         .seen_in    (seen_pad[i]),
         .slot       (slot_pad[i]),
         .valid      (valid_pad[i]),
         .seen_out   (seen_pad[i+1])
      );
   end

   // summarize the chain for the sequencer
   assign chain.head_valid = valid_pad[0];
   assign chain.next_valid = valid_pad[1];
   assign chain.full       = valid_pad[DEPTH-1];
   assign chain.found      = seen_pad[DEPTH];

   fwqr_ctrl #(
      .ID_WIDTH (ID_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .chain     (chain),
      .head_slot (slot_pad[0]),
      .cmd       (cmd),
      .cell_id   (cell_id)
   );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the wait queue with removal
// Sends directed and random queue operations over the request channel. A
// scoreboard keeps its own copy of the queue, predicts each result and
// compares the results in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import fwqr_pkg::*;

   localparam int QUEUE_DEPTH   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 194;
   localparam int REPORT_LIMIT  = 10;

   // One result as it appears on the result channel
   typedef struct packed {
      logic [7:0] out_task;
      status_type status;
      logic       last;
      logic       now_empty;
   } queue_result_type;

   // Shadow queue plus the store of predicted results
   class wait_queue_scoreboard;
      logic [7:0]       entry_q[$];
      queue_result_type predicted_q[$];
      int               errors;
      int               checked;
      int               kind_count[4];
      int               full_hits;
      int               empty_hits;
      int               miss_hits;
      int               deepest;

      function void push_result(logic [7:0] released, status_type status,
                                logic last, logic now_empty);
         queue_result_type r;
         r.out_task  = released;
         r.status    = status;
         r.last      = last;
         r.now_empty = now_empty;
         predicted_q.push_back(r);
      endfunction

      // Apply one accepted request to the shadow queue
      function void note_request(kind_type kind, logic [7:0] task_id);
         logic [7:0] head;
         int         n;
         int         idx;
         kind_count[kind]++;
         case (kind)
            KIND_ENQUEUE: begin
               if (entry_q.size() >= QUEUE_DEPTH) begin
                  full_hits++;
                  push_result(8'd0, STATUS_FULL, 1'b1, entry_q.size() == 0);
               end else begin
                  entry_q.push_back(task_id);
                  push_result(8'd0, STATUS_OK, 1'b1, 1'b0);
               end
            end
            KIND_DEQUEUE: begin
               if (entry_q.size() == 0) begin
                  empty_hits++;
                  push_result(8'd0, STATUS_EMPTY, 1'b1, 1'b1);
               end else begin
                  head = entry_q.pop_front();
                  push_result(head, STATUS_OK, 1'b1, entry_q.size() == 0);
               end
            end
            KIND_DEQ_ALL: begin
               n = entry_q.size();
               if (n == 0) begin
                  empty_hits++;
                  push_result(8'd0, STATUS_EMPTY, 1'b1, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++)
                     push_result(entry_q[i], STATUS_OK, i == n - 1, 1'b1);
                  entry_q.delete();
               end
            end
            default: begin
               // search from the oldest, first match wins
               idx = -1;
               for (int i = 0; i < entry_q.size(); i++) begin
                  if (idx < 0 && entry_q[i] == task_id)
                     idx = i;
               end
               if (idx < 0) begin
                  miss_hits++;
                  push_result(8'd0, STATUS_NOT_FOUND, 1'b1, entry_q.size() == 0);
               end else begin
                  entry_q.delete(idx);
                  push_result(8'd0, STATUS_OK, 1'b1, entry_q.size() == 0);
               end
            end
         endcase
         if (entry_q.size() > deepest)
            deepest = entry_q.size();
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_result(queue_result_type got);
         queue_result_type want;
         checked++;
         if (predicted_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("ERROR: unexpected result task=%0h status=%0d last=%0b empty=%0b",
                        got.out_task, got.status, got.last, got.now_empty);
            return;
         end
         want = predicted_q.pop_front();
         if (got != want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $write("ERROR: result %0d expected task=%0h status=%0d last=%0b empty=%0b, ",
                      checked, want.out_task, want.status, want.last, want.now_empty);
               $display("got task=%0h status=%0d last=%0b empty=%0b",
                        got.out_task, got.status, got.last, got.now_empty);
            end
         end
      endfunction

      function int pending();
         return predicted_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic steady;

   fwqr_req_if req_ch ();
   fwqr_rsp_if rsp_ch ();

   wait_queue_scoreboard sb = new();

   fifo_wait_queue_with_removal_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Drive all inputs to known values from time zero
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      steady         = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_ENQUEUE;
      req_ch.task_id = 8'd0;
      rsp_ch.ready   = 1'b0;
   end

   always #4 clock = ~clock;

   // Stall the result channel about a third of the time
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
   end

   // Check every accepted result
   always @(posedge clock) begin
      queue_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_task  = rsp_ch.out_task;
         got.status    = status_type'(rsp_ch.status);
         got.last      = rsp_ch.last;
         got.now_empty = rsp_ch.now_empty;
         sb.check_result(got);
      end
   end

   // Send one request; starts and ends at a falling edge
   task automatic send_request(kind_type kind, logic [7:0] task_id);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.task_id <= task_id;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      sb.note_request(kind, task_id);
      @(negedge clock);
   endtask

   // Hold off new requests until every predicted result has come
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   // Empty-queue cases, fill to full, overflow, removals, then drain
   task automatic run_directed();
      logic [7:0] fill_ids [16] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80,
                                    8'h7F, 8'hFE, 8'h5A, 8'h10, 8'h20, 8'h40,
                                    8'h02, 8'h04, 8'h08, 8'hC0};
      send_request(KIND_DEQUEUE, 8'h00);
      send_request(KIND_DEQ_ALL, 8'hFF);
      send_request(KIND_REMOVE, 8'h00);
      foreach (fill_ids[i])
         send_request(KIND_ENQUEUE, fill_ids[i]);
      send_request(KIND_ENQUEUE, 8'h33);
      send_request(KIND_REMOVE, 8'h5A);
      send_request(KIND_REMOVE, 8'h42);
      send_request(KIND_DEQUEUE, 8'hAA);
      send_request(KIND_ENQUEUE, 8'hC3);
      send_request(KIND_DEQ_ALL, 8'h55);
   endtask

   // Random requests in phases that fill, drain or mix the queue
   task automatic run_random(int count);
      int         mode;
      int         roll;
      int         t_enq;
      int         t_deq;
      int         t_all;
      kind_type   kind;
      logic [7:0] task_id;
      for (int i = 0; i < count; i++) begin
         if (i == 60)
            wait_for_drain();
         steady = (i >= 100 && i < 160);
         mode = (i / 24) % 3;
         case (mode)
            0:       begin t_enq = 75; t_deq = 82; t_all = 82; end
            1:       begin t_enq = 25; t_deq = 55; t_all = 65; end
            default: begin t_enq = 45; t_deq = 65; t_all = 75; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < t_enq)
            kind = KIND_ENQUEUE;
         else if (roll < t_deq)
            kind = KIND_DEQUEUE;
         else if (roll < t_all)
            kind = KIND_DEQ_ALL;
         else
            kind = KIND_REMOVE;
         task_id = 8'($urandom_range(0, 255));
         // favor duplicates on enqueue and present identifiers on remove
         if (kind == KIND_ENQUEUE && $urandom_range(0, 9) < 3)
            task_id = 8'($urandom_range(0, 3));
         if (kind == KIND_REMOVE && sb.entry_q.size() != 0 && $urandom_range(0, 9) < 7)
            task_id = sb.entry_q[$urandom_range(0, sb.entry_q.size() - 1)];
         send_request(kind, task_id);
      end
      steady = 1'b0;
   endtask

   // Main sequence
   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      wait_for_drain();
      run_random(RANDOM_ITEMS);
      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d enqueue, %0d dequeue, %0d dequeue-all, %0d remove requests",
               sb.kind_count[KIND_ENQUEUE], sb.kind_count[KIND_DEQUEUE],
               sb.kind_count[KIND_DEQ_ALL], sb.kind_count[KIND_REMOVE]);
      $display("%0d results checked; full %0d, empty %0d, no match %0d; deepest %0d",
               sb.checked, sb.full_hits, sb.empty_hits, sb.miss_hits, sb.deepest);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // End a hung run
   initial begin
      #2000000;
      $display("TIMEOUT: %0d results still outstanding", sb.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
rtl/fwqr_pkg.sv
rtl/fwqr_req_if.sv
rtl/fwqr_rsp_if.sv
rtl/fwqr_cell.sv
rtl/fwqr_ctrl.sv
rtl/fifo_wait_queue_with_removal_unit.sv
sim/tb.sv
